// File: sv/mvm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix-vector multiply package
// Shared constants, register indexes and the queue control type.
// ----------------------------------------------------------------------------
package mvm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_COLUMNS_DEF = 4096;
    localparam int VALUE_WIDTH_DEF = 16;

    // Fixed field and register widths
    localparam int INDEX_W   = 12;
    localparam int VLEN_W    = 13;
    localparam int ROWS_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int ACC_W     = 48;
    localparam int OUT_W     = ROWS_W + ACC_W;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 1'd1;

    // Input item kinds
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_WEIGHT = 1'b1;

    // Saturation bounds of the accumulator
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Classification of one queued item
    typedef struct packed {
        logic is_weight;  // weight element, otherwise a vector load
        logic addr_ok;    // load address falls inside the vector store
    } item_ctrl_t;

endpackage

// File: sv/mvm_front.sv
// ----------------------------------------------------------------------------
// Matrix-vector multiply front end
// Accepts input transactions, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module mvm_front #(
    parameter int MAX_COLUMNS = mvm_pkg::MAX_COLUMNS_DEF,
    parameter int VALUE_WIDTH = mvm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_action,
    input  logic [mvm_pkg::INDEX_W-1:0]   in_index,
    input  logic [VALUE_WIDTH-1:0]        in_value,
    output logic                          q_valid,
    input  logic                          q_pop,
    output mvm_pkg::item_ctrl_t           q_ctrl,
    output logic [mvm_pkg::INDEX_W-1:0]   q_index,
    output logic [VALUE_WIDTH-1:0]        q_value
);
    import mvm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_ctrl_t                 ctrl_mem [QUEUE_DEPTH];
    logic [INDEX_W-1:0]         index_mem [QUEUE_DEPTH];
    logic [VALUE_WIDTH-1:0]     value_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;
    item_ctrl_t       in_ctrl;

    assign in_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;

    // Classify the item as it enters the queue.
    always_comb
    begin
        in_ctrl.is_weight = (in_action == ACT_WEIGHT);
        in_ctrl.addr_ok   = (32'(in_index) < 32'(MAX_COLUMNS));
    end

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_mem[wr_ptr_reg]  <= in_ctrl;
            index_mem[wr_ptr_reg] <= in_index;
            value_mem[wr_ptr_reg] <= in_value;
        end
    end

    assign q_ctrl  = ctrl_mem[rd_ptr_reg];
    assign q_index = index_mem[rd_ptr_reg];
    assign q_value = value_mem[rd_ptr_reg];

endmodule

// File: sv/mvm_back.sv
// ----------------------------------------------------------------------------
// Matrix-vector multiply back end
// Vector store, column and row counters, multiply-accumulate and output stage.
// ----------------------------------------------------------------------------
module mvm_back #(
    parameter int MAX_COLUMNS = mvm_pkg::MAX_COLUMNS_DEF,
    parameter int VALUE_WIDTH = mvm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mvm_pkg::VLEN_W-1:0]    vector_length,
    input  logic [mvm_pkg::ROWS_W-1:0]    row_count,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  mvm_pkg::item_ctrl_t           q_ctrl,
    input  logic [mvm_pkg::INDEX_W-1:0]   q_index,
    input  logic [VALUE_WIDTH-1:0]        q_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mvm_pkg::ROWS_W-1:0]    out_row_index,
    output logic [mvm_pkg::ACC_W-1:0]     out_dot_product,
    output logic                          out_last_row
);
    import mvm_pkg::*;

    localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
    localparam int PROD_W = 2 * VALUE_WIDTH;
    localparam int SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;

    logic [VALUE_WIDTH-1:0] store_mem [MAX_COLUMNS];

    logic                   advance;
    logic                   take;
    logic                   take_weight;
    logic [COL_W-1:0]       n_eff;
    logic [ROWS_W-1:0]      d_eff;
    logic [COL_W:0]         col_plus;
    logic                   row_end;
    logic                   row_last;
    logic [ROWS_W:0]        row_plus;

    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROWS_W-1:0]      row_reg, row_next;

    // Stage 2: store data and weight
    logic                   s2_valid_reg;
    logic [VALUE_WIDTH-1:0] rdata_reg;
    logic [VALUE_WIDTH-1:0] s2_value_reg;
    logic                   s2_end_reg;
    logic                   s2_last_reg;
    logic [ROWS_W-1:0]      s2_row_reg;

    // Stage 3: product
    logic                   s3_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                   s3_end_reg;
    logic                   s3_last_reg;
    logic [ROWS_W-1:0]      s3_row_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] sum;
    logic signed [ACC_W-1:0] sat;

    logic                   out_valid_reg;
    logic [ROWS_W-1:0]      out_row_reg;
    logic [ACC_W-1:0]       out_dot_reg;
    logic                   out_last_reg;

    // The whole pipeline moves only when the output register can take a row.
    assign advance     = !out_valid_reg || out_ready;
    assign q_pop       = advance;
    assign take        = advance && q_valid;
    assign take_weight = take && q_ctrl.is_weight;

    // Effective column and row counts: zero counts as one, columns clamp to the store.
    always_comb
    begin
        if (vector_length == '0)
        begin
            n_eff = COL_W'(1);
        end
        else if (32'(vector_length) > 32'(MAX_COLUMNS))
        begin
            n_eff = COL_W'(MAX_COLUMNS);
        end
        else
        begin
            n_eff = COL_W'(vector_length);
        end
        d_eff = (row_count == '0) ? ROWS_W'(1) : row_count;
    end

    always_comb
    begin
        col_plus = {1'b0, col_reg} + 1'b1;
        row_plus = {1'b0, row_reg} + 1'b1;
        row_end  = !(col_plus < {1'b0, n_eff});
        row_last = (row_plus >= {1'b0, d_eff});
        col_next = col_reg;
        row_next = row_reg;
        if (take_weight)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_plus[ROWS_W-1:0];
            end
            else
            begin
                col_next = col_plus[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Vector store: loads write, weights read the element of the current column.
    always_ff @(posedge clk)
    begin
        if (take && !q_ctrl.is_weight && q_ctrl.addr_ok)
        begin
            store_mem[ADDR_W'(q_index)] <= q_value;
        end
        if (take_weight)
        begin
            rdata_reg <= store_mem[col_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_weight)
        begin
            s2_value_reg <= q_value;
            s2_end_reg   <= row_end;
            s2_last_reg  <= row_last;
            s2_row_reg   <= row_reg;
        end
        if (advance)
        begin
            prod_reg    <= $signed(s2_value_reg) * $signed(rdata_reg);
            s3_end_reg  <= s2_end_reg;
            s3_last_reg <= s2_last_reg;
            s3_row_reg  <= s2_row_reg;
        end
    end

    // Accumulate with saturation to the 48-bit range.
    always_comb
    begin
        sum = SUM_W'(acc_reg) + SUM_W'(prod_reg);
        if (sum > SUM_W'(ACC_MAX))
        begin
            sat = ACC_MAX;
        end
        else if (sum < SUM_W'(ACC_MIN))
        begin
            sat = ACC_MIN;
        end
        else
        begin
            sat = sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= take_weight;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg && s3_end_reg;
            if (s3_valid_reg)
            begin
                acc_reg <= s3_end_reg ? '0 : sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s3_valid_reg && s3_end_reg)
        begin
            out_row_reg  <= s3_row_reg;
            out_dot_reg  <= sat;
            out_last_reg <= s3_last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_row_index   = out_row_reg;
    assign out_dot_product = out_dot_reg;
    assign out_last_row    = out_last_reg;

endmodule

// File: sv/matrix_vector_multiply_unit.sv
// ----------------------------------------------------------------------------
// Matrix-vector multiply unit
// Streams a row-major weight matrix against a stored vector, one row result
// per finished row.
// ----------------------------------------------------------------------------
// Usage: the input stream carries two kinds of transaction, chosen by
// s_axis_tuser. A load (tuser 0) writes one element of the vector store at
// the given index; a weight (tuser 1) is multiplied by the stored element of
// the current column and added to a saturating 48-bit accumulator. After
// vector_length weights one row transaction leaves on the output stream with
// its row index and dot product; tlast marks the final row of the matrix.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata while
// the unit is idle and takes effect at once.
// Throughput is one input transaction per cycle, sustained while the output does
// not stall, set by the single store read port and the single multiply-accumulate.
// A row result is shown on m_axis_tvalid once its last weight has passed the
// queue, the store read, the multiply and the accumulate.
// Reset clears the counters, the accumulator and the queue, and sets both
// registers to 1; the vector store holds no defined value until loaded.
// When the receiver stalls, the pipeline holds, the four-entry queue fills,
// and s_axis_tready drops only when that queue is full.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_unit #(
    parameter int MAX_COLUMNS = mvm_pkg::MAX_COLUMNS_DEF,
    parameter int VALUE_WIDTH = mvm_pkg::VALUE_WIDTH_DEF,
    localparam int IN_DATA_W  = ((mvm_pkg::INDEX_W + VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write port
    input  logic                           cfg_wr_en,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mvm_pkg::CFG_W-1:0]      cfg_wdata,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [IN_DATA_W-1:0]           s_axis_tdata,   // element_index, value, zero pad
    input  logic                           s_axis_tuser,   // action
    // Output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [mvm_pkg::OUT_W-1:0]      m_axis_tdata,   // row_index, dot_product
    output logic                           m_axis_tlast    // last_row
);
    import mvm_pkg::*;

    logic [VLEN_W-1:0]      vector_length_reg;
    logic [ROWS_W-1:0]      row_count_reg;

    logic                   q_valid;
    logic                   q_pop;
    item_ctrl_t             q_ctrl;
    logic [INDEX_W-1:0]     q_index;
    logic [VALUE_WIDTH-1:0] q_value;

    logic [ROWS_W-1:0]      row_index;
    logic [ACC_W-1:0]       dot_product;

    // Configuration registers; writes outside the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= VLEN_W'(1);
            row_count_reg     <= ROWS_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_VECTOR_LENGTH: vector_length_reg <= cfg_wdata[VLEN_W-1:0];
                REG_ROW_COUNT:     row_count_reg     <= cfg_wdata[ROWS_W-1:0];
                default:           ;
            endcase
        end
    end

    // The front end accepts and classifies input transactions.
    mvm_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_index  (s_axis_tdata[INDEX_W-1:0]),
        .in_value  (s_axis_tdata[INDEX_W +: VALUE_WIDTH]),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_ctrl    (q_ctrl),
        .q_index   (q_index),
        .q_value   (q_value)
    );

    // The back end owns the vector store and the multiply-accumulate.
    mvm_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .vector_length   (vector_length_reg),
        .row_count       (row_count_reg),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_ctrl          (q_ctrl),
        .q_index         (q_index),
        .q_value         (q_value),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_row_index   (row_index),
        .out_dot_product (dot_product),
        .out_last_row    (m_axis_tlast)
    );

    assign m_axis_tdata = {dot_product, row_index};

endmodule
